>>> sv/srmf_pkg.sv
`default_nettype none
package srmf_pkg;

   localparam int DIST_W  = 10;
   localparam int LIMIT_W = 8;
   localparam int TICK_W  = 16;
   localparam int COUNT_W = 4;
   localparam int QUOT_W  = 13;

   localparam logic [1:0] STATUS_ECHO = 2'd0;

   localparam logic [1:0] CSR_MIN_DISTANCE  = 2'd0;
   localparam logic [1:0] CSR_MAX_DISTANCE  = 2'd1;
   localparam logic [1:0] CSR_ATTEMPT_LIMIT = 2'd2;
   localparam logic [1:0] CSR_TICK_OVERHEAD = 2'd3;

   localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST  = 10'd90;
   localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST  = 10'd900;
   localparam logic [LIMIT_W-1:0] ATTEMPT_LIMIT_RST = 8'd15;
   localparam logic [TICK_W-1:0]  TICK_OVERHEAD_RST = 16'd8800;

   // x / 10 as x * ceil(2^19 / 10) >> 19, exact over 16-bit x
   localparam logic [16:0] DIV10_MUL   = 17'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_DIV3,
      ST_INSERT,
      ST_FINISH
   } srmf_state_type;

   typedef struct packed {
      logic ins;
      logic occ_self;
      logic occ_left;
   } srmf_cell_ctl_type;

   function automatic logic [QUOT_W-1:0] div10(input logic [TICK_W-1:0] x);
      logic [32:0] p;
      p = {17'b0, x} * {16'b0, DIV10_MUL};
      return p[DIV10_SHIFT +: QUOT_W];
   endfunction

endpackage
`default_nettype wire

>>> sv/srmf_cell.sv
`default_nettype none
module srmf_cell
   import srmf_pkg::*;
(
   input  wire logic                 clock,
   input  wire srmf_cell_ctl_type    ctl,
   input  wire logic [DIST_W-1:0]    sample,
   input  wire logic [DIST_W-1:0]    left_val,
   input  wire logic                 left_gt,
   output logic      [DIST_W-1:0]    val,
   output logic                      gt
);

   logic [DIST_W-1:0] val_ff;
   logic [DIST_W-1:0] val_in;
   logic              take_new;

   assign gt  = ctl.occ_self && (val_ff > sample);
   assign val = val_ff;

   // first slot that is empty or larger than the new sample takes it
   assign take_new = ctl.occ_left && (!ctl.occ_self || gt);

   always_comb begin
      val_in = val_ff;
      if (ctl.ins) begin
         if (left_gt) begin
            val_in = left_val;
         end else if (take_new) begin
            val_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule
`default_nettype wire

>>> sv/sonar_range_median_filter.sv
`default_nettype none
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_attempt_status, req_elapsed_ticks
// rsp       out        rsp_valid / rsp_stall   rsp_median_distance, rsp_too_few,
//                                              rsp_valid_samples
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// a request steps through tick offset, three passes through one shared
// divide-by-ten multiplier, one insert step in the sorted cell row and one finish step
// at session end the finish step waits while an earlier response is still stalled
// synchronous active-high reset clears control state and loads register defaults
// the sorted row has no reset; only slots below the sample count are read
module sonar_range_median_filter
   import srmf_pkg::*;
#(
   parameter int SAMPLES_NEEDED = 5
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_attempt_status,
   input  wire logic [TICK_W-1:0]   req_elapsed_ticks,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [DIST_W-1:0]   rsp_median_distance,
   output logic                     rsp_too_few,
   output logic      [COUNT_W-1:0]  rsp_valid_samples,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [TICK_W-1:0]   csr_data
);

   localparam int MEDIAN_IDX = SAMPLES_NEEDED / 2;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SAMPLES_NEEDED);
   localparam logic [COUNT_W-1:0] FEW_LIMIT  = COUNT_W'(SAMPLES_NEEDED / 2 + 1);

   srmf_state_type state_ff, state_in;

   logic [DIST_W-1:0]  min_dist_ff, max_dist_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [TICK_W-1:0]  overhead_ff;

   logic [TICK_W-1:0]  work_ff, work_in;
   logic               neg_ff, echo_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LIMIT_W-1:0] attempt_ff, attempt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_median_ff, rsp_median_in;
   logic               rsp_few_ff, rsp_few_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic accept, div_step, ins_step, fin_step;
   logic [TICK_W-1:0] raw, div_arg, q16;
   logic [QUOT_W-1:0] quot;
   logic dist_ok, ins_en, session_end, rsp_busy, emit;

   logic [DIST_W-1:0] cell_val [SAMPLES_NEEDED];
   logic              cell_gt  [SAMPLES_NEEDED];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIV1;
         ST_DIV1:   state_in = ST_DIV2;
         ST_DIV2:   state_in = ST_DIV3;
         ST_DIV3:   state_in = ST_INSERT;
         ST_INSERT: state_in = ST_FINISH;
         ST_FINISH: if (!(session_end && rsp_busy)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      div_step  = 1'b0;
      ins_step  = 1'b0;
      fin_step  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_DIV1,
         ST_DIV2,
         ST_DIV3:   div_step = 1'b1;
         ST_INSERT: ins_step = 1'b1;
         ST_FINISH: fin_step = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // scaling: |raw| /10, *9 /10, *6 /10 through one divider
   assign raw = req_elapsed_ticks - overhead_ff;
   assign q16 = work_ff;

   always_comb begin
      unique case (state_ff)
         ST_DIV2: div_arg = (q16 << 3) + q16;
         ST_DIV3: div_arg = (q16 << 2) + (q16 << 1);
         default: div_arg = q16;
      endcase
   end

   assign quot = div10(div_arg);

   always_comb begin
      work_in = work_ff;
      if (accept) begin
         work_in = raw[TICK_W-1] ? (~raw + 16'd1) : raw;
      end else if (div_step) begin
         work_in = {{(TICK_W-QUOT_W){1'b0}}, quot};
      end
   end

   // a negative reading survives only when it scales to zero
   assign dist_ok = echo_ff && (!neg_ff || work_ff == '0)
                    && work_ff >= {6'b0, min_dist_ff}
                    && work_ff <= {6'b0, max_dist_ff};
   assign ins_en  = ins_step && dist_ok && (count_ff < FULL_COUNT);

   generate
      for (genvar i = 0; i < SAMPLES_NEEDED; i++) begin : g_cell
         srmf_cell_ctl_type ctl;
         logic [DIST_W-1:0] lval;
         logic              lgt;

         assign ctl.ins      = ins_en;
         assign ctl.occ_self = count_ff > COUNT_W'(i);
         if (i == 0) begin : g_head
            assign ctl.occ_left = 1'b1;
            assign lval         = '0;
            assign lgt          = 1'b0;
         end else begin : g_body
            assign ctl.occ_left = count_ff > COUNT_W'(i - 1);
            assign lval         = cell_val[i-1];
            assign lgt          = cell_gt[i-1];
         end

         srmf_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .sample   (work_ff[DIST_W-1:0]),
            .left_val (lval),
            .left_gt  (lgt),
            .val      (cell_val[i]),
            .gt       (cell_gt[i])
         );
      end
   endgenerate

   // session bookkeeping and response register
   assign session_end = (count_ff >= FULL_COUNT) || (attempt_ff >= limit_ff);
   assign rsp_busy    = rsp_valid_ff && rsp_stall;
   assign emit        = fin_step && session_end && !rsp_busy;

   always_comb begin
      count_in   = count_ff;
      attempt_in = attempt_ff;
      if (accept) begin
         attempt_in = attempt_ff + 8'd1;
      end
      if (ins_en) begin
         count_in = count_ff + 4'd1;
      end
      if (emit) begin
         count_in   = '0;
         attempt_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_busy || emit;
      rsp_median_in = rsp_median_ff;
      rsp_few_in    = rsp_few_ff;
      rsp_count_in  = rsp_count_ff;
      if (emit) begin
         rsp_few_in    = count_ff < FEW_LIMIT;
         rsp_median_in = (count_ff < FEW_LIMIT) ? '0 : cell_val[MEDIAN_IDX];
         rsp_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         attempt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         min_dist_ff  <= MIN_DISTANCE_RST;
         max_dist_ff  <= MAX_DISTANCE_RST;
         limit_ff     <= ATTEMPT_LIMIT_RST;
         overhead_ff  <= TICK_OVERHEAD_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         attempt_ff   <= attempt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MIN_DISTANCE:  min_dist_ff <= csr_data[DIST_W-1:0];
               CSR_MAX_DISTANCE:  max_dist_ff <= csr_data[DIST_W-1:0];
               CSR_ATTEMPT_LIMIT: limit_ff    <= csr_data[LIMIT_W-1:0];
               CSR_TICK_OVERHEAD: overhead_ff <= csr_data;
               default:           overhead_ff <= overhead_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      rsp_median_ff <= rsp_median_in;
      rsp_few_ff    <= rsp_few_in;
      rsp_count_ff  <= rsp_count_in;
      if (accept) begin
         neg_ff  <= raw[TICK_W-1];
         echo_ff <= req_attempt_status == STATUS_ECHO;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_median_distance = rsp_median_ff;
   assign rsp_too_few         = rsp_few_ff;
   assign rsp_valid_samples   = rsp_count_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("sample count above capacity");

   a_few_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_too_few == (rsp_valid_samples < FEW_LIMIT)))
      else $error("too_few disagrees with sample count");

   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_few) |-> rsp_median_distance == '0)
      else $error("median not zero with too_few");

   a_clear_on_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (count_ff == '0 && attempt_ff == '0 && rsp_valid))
      else $error("session not cleared after response");
`endif

endmodule
`default_nettype wire
